[rtl/wildcard_regex_matcher_assert.svh]
// Assertion macros for the wildcard regex matcher.
// No dependencies; included by the top level, which checks its own logic.
`ifndef WILDCARD_REGEX_MATCHER_ASSERT_SVH
`define WILDCARD_REGEX_MATCHER_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Plain property, checked on clk_i outside reset
`define WRM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("wrm assertion failed");
// Implication, checked on clk_i outside reset
`define WRM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("wrm assertion failed");
// Next-cycle implication, checked on clk_i outside reset
`define WRM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("wrm assertion failed");
`else
`define WRM_ASSERT(lbl, prop)
`define WRM_ASSERT_IMP(lbl, ante, cons)
`define WRM_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

[rtl/wrm_pkg.sv]
// Shared types, constants and helpers of the wildcard regex matcher.
// No dependencies; used by wrm_cell, wrm_row and the top level.
package wrm_pkg;

  localparam int unsigned MaxPatternDef = 32;
  localparam logic [7:0]  STAR_BYTE     = 8'd42;

  // Item kind carried in tuser
  typedef enum logic {
    FUNC_PATTERN = 1'b0,
    FUNC_TEXT    = 1'b1
  } wrm_func_e;

  // Pattern fault code reported with every result
  typedef enum logic [1:0] {
    FAULT_NONE     = 2'd0,
    FAULT_OVERFLOW = 2'd1,
    FAULT_STAR     = 2'd2
  } wrm_fault_e;

  // Per-word control broadcast to the cell row
  typedef struct packed {
    logic pat_we;   // pattern byte accepted
    logic txt_we;   // text byte accepted
    logic restart;  // pattern byte after text or a finished pattern: start a new pattern
    logic last;     // final byte of pattern or text
  } wrm_ctl_t;

  // What a cell hands to its right-hand neighbors
  typedef struct packed {
    logic row;   // current match bit
    logic nxt;   // match bit after this text byte
    logic base;  // empty-text match bit
    logic hit;   // stored byte accepts the text byte
  } wrm_link_t;

  localparam wrm_link_t LINK_ZERO = '{row: 1'b0, nxt: 1'b0, base: 1'b0, hit: 1'b0};

  // Only lowercase letters are literal; everything else is a wildcard
  function automatic logic is_literal(input logic [7:0] b);
    is_literal = (b >= 8'd97) && (b <= 8'd122);
  endfunction

endpackage

[rtl/wrm_cell.sv]
// One pattern position of the matcher: stored byte and its match bit.
// Depends on wrm_pkg.
module wrm_cell #(
  parameter bit IS_FIRST = 1'b0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  wrm_pkg::wrm_ctl_t   ctl_i,
  input  logic                sel_i,     // pattern byte lands here
  input  logic [7:0]          ch_i,
  input  wrm_pkg::wrm_link_t  prev1_i,   // position j-1
  input  wrm_pkg::wrm_link_t  prev2_i,   // position j-2
  output wrm_pkg::wrm_link_t  link_o,
  output logic                row_d_o
);
  import wrm_pkg::*;

  logic [7:0] byte_q;
  logic       row_q, row_d;
  logic       is_star, hit, nxt, base, base_app;

  assign is_star = (byte_q == STAR_BYTE);
  assign hit     = !is_literal(byte_q) || (byte_q == ch_i);

  // text step: star repeats the element before it, a leading star matches nothing
  always_comb begin
    if (is_star) begin
      nxt = !IS_FIRST && (prev2_i.nxt || (prev1_i.hit && row_q));
    end else begin
      nxt = hit && prev1_i.row;
    end
  end

  // empty-text bit from stored pattern, and for a byte being appended
  assign base     = is_star && !IS_FIRST && prev2_i.base;
  assign base_app = (ch_i == STAR_BYTE) && !IS_FIRST && prev2_i.row;

  always_comb begin
    if (sel_i) begin
      row_d = base_app;
    end else if (ctl_i.txt_we) begin
      row_d = ctl_i.last ? base : nxt;
    end else begin
      row_d = row_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= 1'b0;
    end else begin
      row_q <= row_d;
    end
  end

  // pattern byte store, no reset
  always_ff @(posedge clk_i) begin
    if (sel_i) begin
      byte_q <= ch_i;
    end
  end

  assign link_o  = '{row: row_q, nxt: nxt, base: base, hit: hit};
  assign row_d_o = row_d;

endmodule

[rtl/wrm_row.sv]
// Row of pattern cells plus the leading match bit and result selection.
// Depends on wrm_pkg and wrm_cell.
module wrm_row #(
  parameter int unsigned MAX_PATTERN = wrm_pkg::MaxPatternDef,
  localparam int unsigned LenW       = $clog2(MAX_PATTERN + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  wrm_pkg::wrm_ctl_t ctl_i,
  input  logic [7:0]        ch_i,
  input  logic [LenW-1:0]   len_i,     // length before this word, after restart
  input  logic [LenW-1:0]   len_d_i,   // length after this word
  output logic              matched_o
);
  import wrm_pkg::*;

  logic                 row0_q, row0_d;
  wrm_link_t            link [MAX_PATTERN+1];
  logic [MAX_PATTERN:0] rowd_v;
  logic [MAX_PATTERN:0] nxt_v;

  // leading bit: empty prefix of the pattern
  always_comb begin
    if (ctl_i.restart) begin
      row0_d = 1'b1;
    end else if (ctl_i.txt_we) begin
      row0_d = ctl_i.last;
    end else begin
      row0_d = row0_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row0_q <= 1'b1;
    end else begin
      row0_q <= row0_d;
    end
  end

  assign link[0]   = '{row: row0_q, nxt: 1'b0, base: 1'b1, hit: 1'b0};
  assign rowd_v[0] = row0_d;
  assign nxt_v[0]  = 1'b0;

  // cell chain
  for (genvar j = 1; j <= MAX_PATTERN; j++) begin : g_cell
    wrm_link_t p2;
    logic      sel;

    if (j == 1) begin : g_edge
      assign p2 = LINK_ZERO;
    end else begin : g_mid
      assign p2 = link[j-2];
    end

    assign sel = ctl_i.pat_we && (len_i == LenW'(j - 1));

    wrm_cell #(
      .IS_FIRST (j == 1)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl_i),
      .sel_i   (sel),
      .ch_i    (ch_i),
      .prev1_i (link[j-1]),
      .prev2_i (p2),
      .link_o  (link[j]),
      .row_d_o (rowd_v[j])
    );

    assign nxt_v[j] = link[j].nxt;
  end

  // bit at the pattern end: before base rebuild for text, after append for pattern
  always_comb begin
    if (ctl_i.txt_we) begin
      matched_o = nxt_v[len_i];
    end else begin
      matched_o = ctl_i.last && rowd_v[len_d_i];
    end
  end

endmodule

[rtl/wildcard_regex_matcher.sv]
// Wildcard regex matcher: one byte per word, one result word per input word.
// The result word is registered in the output register at the edge that takes the input word.
// Throughput: one word per cycle; the cell row resolves a text byte in one pass.
// A stalled output holds back input only while its register is full and not taken.
// Reset (rst_ni low, async) empties the pattern, clears faults and expects pattern bytes.
// Depends on wrm_pkg, wrm_row and wildcard_regex_matcher_assert.svh.
`include "wildcard_regex_matcher_assert.svh"

module wildcard_regex_matcher #(
  parameter int unsigned MAX_PATTERN = wrm_pkg::MaxPatternDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,    // [7:0] ch
  input  logic       s_axis_tuser,    // [0] func
  input  logic       s_axis_tlast,    // last
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,    // [0] matched, [7:1] zero
  output logic [1:0] m_axis_tuser,    // [1:0] status
  output logic       m_axis_tlast     // final_res
);
  import wrm_pkg::*;

  localparam int unsigned LenW = $clog2(MAX_PATTERN + 1);

  logic            in_acc;
  logic            loading_q, loading_d;
  logic [LenW-1:0] len_q, len_d, len_eff;
  wrm_fault_e      fault_q, fault_d, fault_eff;
  wrm_ctl_t        ctl;
  logic            matched;

  logic            m_valid_q;
  logic            m_matched_q, m_final_q;
  wrm_fault_e      m_status_q;

  assign s_axis_tready = !m_valid_q || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // control for the row
  always_comb begin
    ctl.pat_we  = in_acc && (s_axis_tuser == FUNC_PATTERN);
    ctl.txt_we  = in_acc && (s_axis_tuser == FUNC_TEXT);
    ctl.restart = ctl.pat_we && !loading_q;
    ctl.last    = s_axis_tlast;
  end

  // pattern length, fault and load-mode bookkeeping
  always_comb begin
    len_eff   = ctl.restart ? '0 : len_q;
    fault_eff = ctl.restart ? FAULT_NONE : fault_q;
    len_d     = len_q;
    fault_d   = fault_q;
    loading_d = loading_q;
    if (ctl.pat_we) begin
      len_d   = len_eff;
      fault_d = fault_eff;
      if (len_eff < LenW'(MAX_PATTERN)) begin
        len_d = len_eff + LenW'(1);
        if ((len_eff == '0) && (s_axis_tdata == STAR_BYTE) && (fault_eff == FAULT_NONE)) begin
          fault_d = FAULT_STAR;
        end
      end else if (fault_eff == FAULT_NONE) begin
        fault_d = FAULT_OVERFLOW;
      end
      loading_d = !s_axis_tlast;
    end else if (ctl.txt_we) begin
      loading_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q     <= '0;
      fault_q   <= FAULT_NONE;
      loading_q <= 1'b1;
    end else begin
      len_q     <= len_d;
      fault_q   <= fault_d;
      loading_q <= loading_d;
    end
  end

  wrm_row #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_row (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (ctl),
    .ch_i      (s_axis_tdata),
    .len_i     (len_eff),
    .len_d_i   (len_d),
    .matched_o (matched)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (in_acc) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      m_matched_q <= matched;
      m_final_q   <= s_axis_tlast;
      m_status_q  <= fault_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {7'd0, m_matched_q};
  assign m_axis_tuser  = m_status_q;
  assign m_axis_tlast  = m_final_q;

  // checks
  `WRM_ASSERT(a_len_bound, len_q <= LenW'(MAX_PATTERN))
  `WRM_ASSERT_IMP(a_star_needs_len, fault_q == FAULT_STAR, len_q != '0)
  `WRM_ASSERT_NXT(a_fault_sticky, (fault_q != FAULT_NONE) && !ctl.restart, $stable(fault_q))
  `WRM_ASSERT_NXT(a_text_last_final, ctl.txt_we && s_axis_tlast, m_valid_q && m_final_q)

endmodule

[sim/tb_wildcard_regex_matcher.sv]
// Self-checking bench for wildcard_regex_matcher: directed table, then random pattern/text runs.
// Depends on wrm_pkg and the wildcard_regex_matcher RTL; keeps its own model of the match row.
module tb_wildcard_regex_matcher;
  import wrm_pkg::*;

  localparam int unsigned PatDepth    = MaxPatternDef;
  localparam int          RandWords   = 1950;
  localparam int          CycleLimit  = 400000;
  localparam logic [7:0]  DotByte     = 8'h2E;

  // Expected result word
  typedef struct packed {
    logic       matched;
    logic       final_res;
    wrm_fault_e status;
  } verdict_t;

  // One row of the directed table; typed = expected result given inline
  typedef struct packed {
    wrm_func_e  func;
    logic [7:0] ch;
    logic       last;
    bit         typed;
    verdict_t   want;
  } stim_row_t;

  localparam int DirRows = 25;
  localparam stim_row_t DirTab [DirRows] = '{
    // text byte against the empty pattern right after reset
    '{FUNC_TEXT,    "a",       1'b1, 1'b1, '{1'b0, 1'b1, FAULT_NONE}},
    // pattern a* : empty text matches
    '{FUNC_PATTERN, "a",       1'b0, 1'b1, '{1'b0, 1'b0, FAULT_NONE}},
    '{FUNC_PATTERN, STAR_BYTE, 1'b1, 1'b1, '{1'b1, 1'b1, FAULT_NONE}},
    '{FUNC_TEXT,    "a",       1'b0, 1'b0, '0},
    '{FUNC_TEXT,    "a",       1'b1, 1'b0, '0},
    '{FUNC_TEXT,    "b",       1'b1, 1'b0, '0},
    // leading star
    '{FUNC_PATTERN, STAR_BYTE, 1'b1, 1'b1, '{1'b0, 1'b1, FAULT_STAR}},
    '{FUNC_TEXT,    8'h00,     1'b1, 1'b0, '0},
    // star after star
    '{FUNC_PATTERN, STAR_BYTE, 1'b0, 1'b1, '{1'b0, 1'b0, FAULT_STAR}},
    '{FUNC_PATTERN, STAR_BYTE, 1'b1, 1'b0, '0},
    '{FUNC_TEXT,    8'hFF,     1'b0, 1'b0, '0},
    '{FUNC_TEXT,    STAR_BYTE, 1'b1, 1'b0, '0},
    // lowercase bounds; load ended by a text byte
    '{FUNC_PATTERN, "z",       1'b0, 1'b1, '{1'b0, 1'b0, FAULT_NONE}},
    '{FUNC_PATTERN, 8'h7B,     1'b0, 1'b0, '0},
    '{FUNC_PATTERN, 8'h60,     1'b0, 1'b0, '0},
    '{FUNC_PATTERN, "a",       1'b0, 1'b0, '0},
    '{FUNC_TEXT,    "z",       1'b0, 1'b0, '0},
    '{FUNC_TEXT,    "q",       1'b0, 1'b0, '0},
    '{FUNC_TEXT,    "#",       1'b0, 1'b0, '0},
    '{FUNC_TEXT,    "a",       1'b1, 1'b0, '0},
    // wildcard star then literal
    '{FUNC_PATTERN, 8'hFF,     1'b0, 1'b0, '0},
    '{FUNC_PATTERN, STAR_BYTE, 1'b0, 1'b0, '0},
    '{FUNC_PATTERN, "b",       1'b1, 1'b0, '0},
    '{FUNC_TEXT,    "b",       1'b1, 1'b0, '0},
    '{FUNC_TEXT,    8'h80,     1'b1, 1'b0, '0}
  };

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata  = '0;
  logic       s_axis_tuser  = 1'b0;
  logic       s_axis_tlast  = 1'b0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;
  logic       m_axis_tlast;

  wildcard_regex_matcher #(.MAX_PATTERN(PatDepth)) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #2 clk_i = ~clk_i;

  // Model state
  logic [7:0]      pat_mem [PatDepth];
  int unsigned     pat_len;
  logic [PatDepth:0] match_row;
  bit              loading;
  wrm_fault_e      fault;

  verdict_t verdict_q [$];
  int       mismatch_cnt = 0;
  int       result_cnt   = 0;
  int       sent_cnt     = 0;
  int       cycle_cnt    = 0;
  int       send_idle_pct = 0;
  int       recv_idle_pct = 0;

  function automatic bit is_lower(input logic [7:0] b);
    return b >= "a" && b <= "z";
  endfunction

  // Empty-text cell j, from the cells below it
  function automatic logic empty_text_cell(input int unsigned j);
    if (pat_mem[j-1] != STAR_BYTE || j < 2) return 1'b0;
    return match_row[j-2];
  endfunction

  function automatic void clear_model();
    pat_len   = 0;
    match_row = '0;
    match_row[0] = 1'b1;
    loading   = 1'b1;
    fault     = FAULT_NONE;
  endfunction

  // Advance the model by one accepted word and return its result
  function automatic verdict_t match_step(input wrm_func_e func, input logic [7:0] ch,
                                          input logic last);
    verdict_t          v;
    logic [PatDepth:0] nxt;
    logic [7:0]        pc, prev;
    v = '0;
    if (func == FUNC_PATTERN) begin
      if (!loading) clear_model();
      if (pat_len < PatDepth) begin
        pat_mem[pat_len] = ch;
        pat_len++;
        if (pat_len == 1 && ch == STAR_BYTE && fault == FAULT_NONE) fault = FAULT_STAR;
        match_row[pat_len] = empty_text_cell(pat_len);
      end else if (fault == FAULT_NONE) begin
        fault = FAULT_OVERFLOW;
      end
      if (last) begin
        loading     = 1'b0;
        v.matched   = match_row[pat_len];
        v.final_res = 1'b1;
      end
    end else begin
      loading = 1'b0;
      nxt = '0;
      for (int unsigned j = 1; j <= pat_len; j++) begin
        pc = pat_mem[j-1];
        if (pc != STAR_BYTE) begin
          nxt[j] = (is_lower(pc) && pc != ch) ? 1'b0 : match_row[j-1];
        end else if (j < 2) begin
          nxt[j] = 1'b0;
        end else begin
          prev = pat_mem[j-2];
          if (is_lower(prev) && prev != ch) nxt[j] = nxt[j-2];
          else nxt[j] = nxt[j-2] | match_row[j];
        end
      end
      for (int unsigned j = 0; j <= pat_len; j++) match_row[j] = nxt[j];
      v.matched   = match_row[pat_len];
      v.final_res = last;
      if (last) begin
        // back to the empty-text row for the next text
        match_row = '0;
        match_row[0] = 1'b1;
        for (int unsigned j = 1; j <= pat_len; j++) match_row[j] = empty_text_cell(j);
      end
    end
    v.status = fault;
    return v;
  endfunction

  // Send one word; the expectation is queued when the handshake is seen
  task automatic send_word(input wrm_func_e func, input logic [7:0] ch, input logic last,
                           input bit use_typed = 1'b0, input verdict_t typed_v = '0);
    bit       taken;
    verdict_t v;
    // idling phases: receiver slow, then sender slow, then neither
    case (sent_cnt * 3 / (DirRows + RandWords))
      0:       begin send_idle_pct = 19; recv_idle_pct = 80; end
      1:       begin send_idle_pct = 80; recv_idle_pct = 19; end
      default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
    endcase
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= func;
    s_axis_tdata  <= ch;
    s_axis_tlast  <= last;
    do begin
      @(negedge clk_i);
      taken = s_axis_tready;
      @(posedge clk_i);
    end while (!taken);
    v = match_step(func, ch, last);
    verdict_q.push_back(use_typed ? typed_v : v);
    sent_cnt++;
  endtask

  function automatic logic [7:0] pick_pattern_byte();
    int r;
    r = $urandom_range(99);
    if (r < 40) return 8'("a" + $urandom_range(2));
    if (r < 60) return STAR_BYTE;
    if (r < 75) return DotByte;
    if (r < 85) return 8'("a" + $urandom_range(25));
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [7:0] pick_text_byte();
    int r;
    r = $urandom_range(99);
    if (r < 70) return 8'("a" + $urandom_range(2));
    if (r < 80) return 8'("a" + $urandom_range(25));
    return 8'($urandom_range(255));
  endfunction

  // Receiver backpressure
  always @(posedge clk_i) m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Result checker: outputs are stable at the falling edge before the taking edge
  always @(negedge clk_i) begin
    verdict_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (verdict_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected result word %0d: tdata=%h final=%0b status=%0d",
                   result_cnt, m_axis_tdata, m_axis_tlast, m_axis_tuser);
      end else begin
        want = verdict_q.pop_front();
        if (m_axis_tdata !== {7'd0, want.matched} || m_axis_tlast !== want.final_res ||
            m_axis_tuser !== want.status) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("mismatch word %0d: want m=%0b f=%0b st=%0d, got tdata=%h f=%0b st=%0d",
                     result_cnt, want.matched, want.final_res, want.status,
                     m_axis_tdata, m_axis_tlast, m_axis_tuser);
        end
      end
      result_cnt++;
    end
  end

  initial begin
    logic [7:0] pat [$];
    logic [7:0] txt [$];
    int         plen, ntext, reps;
    bit         broken, starred;
    clear_model();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table
    foreach (DirTab[i])
      send_word(DirTab[i].func, DirTab[i].ch, DirTab[i].last, DirTab[i].typed, DirTab[i].want);

    // Random runs: a pattern, then a few texts, with some noise and broken loads
    while (sent_cnt < DirRows + RandWords) begin
      if ($urandom_range(99) < 5) begin
        send_word(wrm_func_e'($urandom_range(1)), 8'($urandom_range(255)),
                  1'($urandom_range(1)));
      end else begin
        plen = ($urandom_range(99) < 6) ? $urandom_range(PatDepth - 2, PatDepth + 4)
                                        : $urandom_range(1, 8);
        pat.delete();
        for (int k = 0; k < plen; k++) pat.push_back(pick_pattern_byte());
        broken = ($urandom_range(99) < 10);
        for (int k = 0; k < plen; k++)
          send_word(FUNC_PATTERN, pat[k], !broken && k == plen - 1);
        ntext = $urandom_range(1, 4);
        for (int t = 0; t < ntext; t++) begin
          txt.delete();
          if ($urandom_range(99) < 60) begin
            // text grown from the pattern, so that matches are common
            for (int k = 0; k < plen; k++) begin
              if (pat[k] == STAR_BYTE) continue;
              starred = (k + 1 < plen) && (pat[k+1] == STAR_BYTE);
              reps = starred ? $urandom_range(3) : 1;
              for (int n = 0; n < reps; n++)
                txt.push_back(is_lower(pat[k]) ? pat[k] : pick_text_byte());
            end
            if (txt.size() > 0 && $urandom_range(99) < 15)
              txt[$urandom_range(txt.size() - 1)] = pick_text_byte();
          end else begin
            reps = $urandom_range(1, 10);
            for (int n = 0; n < reps; n++) txt.push_back(pick_text_byte());
          end
          if (txt.size() == 0) txt.push_back(pick_text_byte());
          foreach (txt[k]) send_word(FUNC_TEXT, txt[k], k == txt.size() - 1);
        end
      end
    end
    s_axis_tvalid <= 1'b0;

    // Drain
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatch_cnt == 0 && verdict_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[wildcard_regex_matcher.f]
+incdir+rtl
rtl/wrm_pkg.sv
rtl/wrm_cell.sv
rtl/wrm_row.sv
rtl/wildcard_regex_matcher.sv
sim/tb_wildcard_regex_matcher.sv
